/* src/rsa_key_and_char_cipher_top_assert.svh */
// Assertion macros used by the cipher's top-level RTL file.
`ifndef RSA_KEY_AND_CHAR_CIPHER_TOP_ASSERT_SVH
`define RSA_KEY_AND_CHAR_CIPHER_TOP_ASSERT_SVH

// The antecedent holding implies the consequent in the same cycle.
`define RKC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rkc assertion failed");

// The antecedent holding implies the consequent in the next cycle.
`define RKC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rkc assertion failed");

// The expression never holds.
`define RKC_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rkc assertion failed");

`endif

/* src/rkc_pkg.sv */
// Package with shared types and constants of the RSA cipher block.
package rkc_pkg;

    localparam int PRIME_BITS_DEF = 16;
    localparam int PW = 16;   // width of a prime register
    localparam int W  = 32;   // word width of modulus, exponents and data
    localparam int SW = 35;   // signed width of the Bezout coefficients

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_PRIME = 2'd1;
    localparam logic [1:0] ST_BAD_EXP   = 2'd2;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [1:0] CFG_PRIME_P = 2'd0;
    localparam logic [1:0] CFG_PRIME_Q = 2'd1;
    localparam logic [1:0] CFG_PUB_EXP = 2'd2;

    typedef struct packed {
        logic          cmd;
        logic [W-1:0]  value;
    } rkc_in_t;

    typedef struct packed {
        logic [W-1:0]  result;
        logic [1:0]    status;
    } rkc_out_t;

    // Request to a serial arithmetic unit.
    typedef struct packed {
        logic start;
        logic plain;
    } unit_req_t;

endpackage

/* src/rkc_mulmod.sv */
// Bit-serial modular multiplier (plain product in plain mode), one multiplier bit per cycle.
module rkc_mulmod
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rkc_pkg::unit_req_t    req,
    input  logic [rkc_pkg::W-1:0] x,
    input  logic [rkc_pkg::W-1:0] y,
    input  logic [rkc_pkg::W-1:0] m,
    output logic                  done,
    output logic [rkc_pkg::W-1:0] z
);

    localparam int W  = rkc_pkg::W;
    localparam int CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          plain_reg, plain_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W+1:0]  acc_reg, acc_next;
    logic [W-1:0]  xs_reg, xs_next;
    logic [W+2:0]  t;
    logic [W+2:0]  m1;
    logic [W+2:0]  m2;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        plain_next = plain_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        xs_next    = xs_reg;
        // Shift the partial sum and add the multiplicand on a one bit.
        t  = {acc_reg, 1'b0} + (xs_reg[W-1] ? {3'b000, y} : '0);
        m1 = {3'b000, m};
        m2 = {2'b00, m, 1'b0};
        if (req.start)
        begin
            busy_next  = 1'b1;
            plain_next = req.plain;
            cnt_next   = '0;
            acc_next   = '0;
            xs_next    = x;
        end
        else if (busy_reg)
        begin
            if (plain_reg)
                acc_next = t[W+1:0];
            else if (t >= m2)
                acc_next = (W+2)'(t - m2);
            else if (t >= m1)
                acc_next = (W+2)'(t - m1);
            else
                acc_next = t[W+1:0];
            xs_next  = {xs_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plain_reg <= plain_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        xs_reg    <= xs_next;
    end

    assign done = done_reg;
    assign z    = acc_reg[W-1:0];

endmodule

/* src/rkc_div.sv */
// Bit-serial restoring divider; also folds the quotient times a signed coefficient.
module rkc_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rkc_pkg::unit_req_t            req,
    input  logic [rkc_pkg::W-1:0]         n,
    input  logic [rkc_pkg::W-1:0]         d,
    input  logic signed [rkc_pkg::SW-1:0] s,
    output logic                          done,
    output logic [rkc_pkg::W-1:0]         rem,
    output logic signed [rkc_pkg::SW-1:0] prod
);

    localparam int W  = rkc_pkg::W;
    localparam int SW = rkc_pkg::SW;
    localparam int CW = $clog2(W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         ns_reg, ns_next;
    logic signed [SW-1:0] prod_reg, prod_next;
    logic [W:0]           t;
    logic                 ge;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        ns_next   = ns_reg;
        prod_next = prod_reg;
        t  = {rem_reg, ns_reg[W-1]};
        ge = (t >= {1'b0, d});
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            ns_next   = n;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? W'(t - {1'b0, d}) : t[W-1:0];
            ns_next   = {ns_reg[W-2:0], 1'b0};
            prod_next = (prod_reg <<< 1) + (ge ? s : '0);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        ns_reg   <= ns_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign prod = prod_reg;

endmodule

/* src/rsa_key_and_char_cipher_top.sv */
// Top level of the textbook RSA cipher with on-demand key derivation.
//
//  channel   direction  handshake              payload
//  cmd       in         cmd_valid / cmd_stall  cmd_data  (cmd, value)
//  rsp       out        rsp_valid / rsp_stall  rsp_data  (result, status)
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// One command is worked on at a time; cmd_stall is high from the transfer
// until the result has been loaded into the output register. Each multiply,
// reduction and division step goes through a bit-serial unit. With a fresh
// key an encrypt or decrypt reduces the input, then squares once per exponent
// bit and multiplies once per one bit of the exponent. After a configuration
// write the key is derived first: two products, trial division of both
// primes and the extended Euclid loop, one division per quotient.
// Reset is asynchronous; it clears the state, primes, exponents, modulus, status and rsp_valid.
// A stalled result waits in the output register; the next command is taken
// while it waits, and only the final load waits for the register to drain.
module rsa_key_and_char_cipher_top
#(
    parameter int PRIME_BITS = rkc_pkg::PRIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [rkc_pkg::W-1:0] cfg_data,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  rkc_pkg::rkc_in_t      cmd_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rkc_pkg::rkc_out_t     rsp_data
);

`include "rsa_key_and_char_cipher_top_assert.svh"

    localparam int W  = rkc_pkg::W;
    localparam int PW = rkc_pkg::PW;
    localparam int SW = rkc_pkg::SW;

    // Only the low PRIME_BITS bits (at most PW) of each prime register take part.
    localparam logic [63:0] PMASK64 = (PRIME_BITS >= 32) ? 64'hFFFF_FFFF :
                                      ((64'd1 << PRIME_BITS) - 64'd1);
    localparam logic [PW-1:0] PMASK = PMASK64[PW-1:0];

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MULM   = 10'b00_0000_0010,
        S_MULPHI = 10'b00_0000_0100,
        S_PRIME  = 10'b00_0000_1000,
        S_CHKE   = 10'b00_0001_0000,
        S_EUC    = 10'b00_0010_0000,
        S_FIX    = 10'b00_0100_0000,
        S_RED    = 10'b00_1000_0000,
        S_EXP    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic                 run_reg, run_next;
    logic                 fresh_reg, fresh_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [PW-1:0]        q_reg, q_next;
    logic [W-1:0]         e_reg, e_next;
    logic [W-1:0]         dk_reg, dk_next;
    logic [W-1:0]         m_reg, m_next;
    logic [1:0]           st_reg, st_next;
    logic [W-1:0]         phi_reg, phi_next;
    logic                 cmd_reg, cmd_next;
    logic [W-1:0]         val_reg, val_next;
    logic                 which_reg, which_next;
    logic [8:0]           dv_reg, dv_next;
    logic [16:0]          sq_reg, sq_next;
    logic [W-1:0]         oldr_reg, oldr_next;
    logic [W-1:0]         curr_reg, curr_next;
    logic signed [SW-1:0] olds_reg, olds_next;
    logic signed [SW-1:0] curs_reg, curs_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [W-1:0]         base_reg, base_next;
    logic [W-1:0]         ex_reg, ex_next;
    logic                 ph_reg, ph_next;
    logic [W-1:0]         res_reg, res_next;
    logic                 ov_reg, ov_next;
    rkc_pkg::rkc_out_t    out_reg, out_next;

    logic [PW-1:0]        p_eff;
    logic [PW-1:0]        q_eff;
    logic [PW-1:0]        n_cur;
    logic signed [SW-1:0] fixed_s;

    rkc_pkg::unit_req_t   mm_req;
    logic [W-1:0]         mm_x, mm_y;
    logic                 mm_done;
    logic [W-1:0]         mm_z;
    rkc_pkg::unit_req_t   dv_req;
    logic [W-1:0]         dv_n, dv_d;
    logic signed [SW-1:0] dv_s;
    logic                 dv_done;
    logic [W-1:0]         dv_rem;
    logic signed [SW-1:0] dv_prod;

    assign p_eff   = p_reg & PMASK;
    assign q_eff   = q_reg & PMASK;
    assign n_cur   = which_reg ? q_eff : p_eff;
    assign fixed_s = olds_reg + $signed({3'b000, phi_reg});

    // Operand selection for the shared serial units.
    always_comb
    begin
        mm_x = {16'h0000, p_eff};
        mm_y = {16'h0000, q_eff};
        case (state_reg)
            S_MULPHI:
            begin
                mm_x = {16'h0000, PW'(p_eff - 1'b1)};
                mm_y = {16'h0000, PW'(q_eff - 1'b1)};
            end
            S_RED:
            begin
                mm_x = (cmd_reg == rkc_pkg::CMD_DEC) ? val_reg : {24'h000000, val_reg[7:0]};
                mm_y = W'(1);
            end
            S_EXP:
            begin
                mm_x = ph_reg ? base_reg : acc_reg;
                mm_y = base_reg;
            end
            default:
            begin
                mm_x = {16'h0000, p_eff};
                mm_y = {16'h0000, q_eff};
            end
        endcase
        if (state_reg == S_EUC)
        begin
            dv_n = oldr_reg;
            dv_d = curr_reg;
            dv_s = curs_reg;
        end
        else
        begin
            dv_n = {16'h0000, n_cur};
            dv_d = {23'h000000, dv_reg};
            dv_s = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        run_next   = run_reg;
        fresh_next = fresh_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        e_next     = e_reg;
        dk_next    = dk_reg;
        m_next     = m_reg;
        st_next    = st_reg;
        phi_next   = phi_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        which_next = which_reg;
        dv_next    = dv_reg;
        sq_next    = sq_reg;
        oldr_next  = oldr_reg;
        curr_next  = curr_reg;
        olds_next  = olds_reg;
        curs_next  = curs_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        ex_next    = ex_reg;
        ph_next    = ph_reg;
        res_next   = res_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        mm_req     = '0;
        dv_req     = '0;

        if (ov_reg && !rsp_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd_data.cmd;
                    val_next   = cmd_data.value;
                    state_next = fresh_reg ? S_RED : S_MULM;
                end
            end
            S_MULM:
            begin
                if (!run_reg)
                begin
                    mm_req   = '{start: 1'b1, plain: 1'b1};
                    run_next = 1'b1;
                end
                else if (mm_done)
                begin
                    run_next   = 1'b0;
                    m_next     = mm_z;
                    dk_next    = '0;
                    state_next = S_MULPHI;
                end
            end
            S_MULPHI:
            begin
                if (!run_reg)
                begin
                    mm_req   = '{start: 1'b1, plain: 1'b1};
                    run_next = 1'b1;
                end
                else if (mm_done)
                begin
                    run_next   = 1'b0;
                    phi_next   = mm_z;
                    which_next = 1'b0;
                    dv_next    = 9'd2;
                    sq_next    = 17'd4;
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                // Trial division by each d from 2 with d*d <= n, until one divides n.
                if (!run_reg)
                begin
                    if (n_cur < PW'(2))
                    begin
                        st_next    = rkc_pkg::ST_NOT_PRIME;
                        fresh_next = 1'b1;
                        state_next = S_RED;
                    end
                    else if (sq_reg > {1'b0, n_cur})
                    begin
                        if (which_reg)
                            state_next = S_CHKE;
                        else
                        begin
                            which_next = 1'b1;
                            dv_next    = 9'd2;
                            sq_next    = 17'd4;
                        end
                    end
                    else
                    begin
                        dv_req   = '{start: 1'b1, plain: 1'b0};
                        run_next = 1'b1;
                    end
                end
                else if (dv_done)
                begin
                    run_next = 1'b0;
                    if (dv_rem == '0)
                    begin
                        st_next    = rkc_pkg::ST_NOT_PRIME;
                        fresh_next = 1'b1;
                        state_next = S_RED;
                    end
                    else
                    begin
                        dv_next = dv_reg + 1'b1;
                        sq_next = sq_reg + {7'b0000000, dv_reg, 1'b1};
                    end
                end
            end
            S_CHKE:
            begin
                if (e_reg == '0 || e_reg >= phi_reg)
                begin
                    st_next    = rkc_pkg::ST_BAD_EXP;
                    fresh_next = 1'b1;
                    state_next = S_RED;
                end
                else
                begin
                    oldr_next  = phi_reg;
                    curr_next  = e_reg;
                    olds_next  = '0;
                    curs_next  = SW'(1);
                    state_next = S_EUC;
                end
            end
            S_EUC:
            begin
                // Extended Euclid; the remainder left at the end is the gcd.
                if (!run_reg)
                begin
                    if (curr_reg == '0)
                    begin
                        if (oldr_reg != W'(1))
                        begin
                            st_next    = rkc_pkg::ST_BAD_EXP;
                            fresh_next = 1'b1;
                            state_next = S_RED;
                        end
                        else
                            state_next = S_FIX;
                    end
                    else
                    begin
                        dv_req   = '{start: 1'b1, plain: 1'b0};
                        run_next = 1'b1;
                    end
                end
                else if (dv_done)
                begin
                    run_next  = 1'b0;
                    oldr_next = curr_reg;
                    curr_next = dv_rem;
                    olds_next = curs_reg;
                    curs_next = olds_reg - dv_prod;
                end
            end
            S_FIX:
            begin
                dk_next    = (olds_reg < 0) ? fixed_s[W-1:0] : olds_reg[W-1:0];
                st_next    = rkc_pkg::ST_OK;
                fresh_next = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                if (!run_reg)
                begin
                    if (st_reg != rkc_pkg::ST_OK)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mm_req   = '{start: 1'b1, plain: 1'b0};
                        run_next = 1'b1;
                        acc_next = (m_reg == W'(1)) ? '0 : W'(1);
                        ex_next  = (cmd_reg == rkc_pkg::CMD_DEC) ? dk_reg : e_reg;
                    end
                end
                else if (mm_done)
                begin
                    run_next   = 1'b0;
                    base_next  = mm_z;
                    ph_next    = 1'b0;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                // Right-to-left square and multiply, one exponent bit per pass.
                if (!run_reg)
                begin
                    if (ex_reg == '0)
                    begin
                        res_next   = (cmd_reg == rkc_pkg::CMD_DEC) ?
                                     {24'h000000, acc_reg[7:0]} : acc_reg;
                        state_next = S_DONE;
                    end
                    else if (!ph_reg && !ex_reg[0])
                        ph_next = 1'b1;
                    else
                    begin
                        mm_req   = '{start: 1'b1, plain: 1'b0};
                        run_next = 1'b1;
                    end
                end
                else if (mm_done)
                begin
                    run_next = 1'b0;
                    if (!ph_reg)
                    begin
                        acc_next = mm_z;
                        ph_next  = 1'b1;
                    end
                    else
                    begin
                        base_next = mm_z;
                        ph_next   = 1'b0;
                        ex_next   = {1'b0, ex_reg[W-1:1]};
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !rsp_stall)
                begin
                    ov_next    = 1'b1;
                    out_next   = '{result: res_reg, status: st_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                run_next   = 1'b0;
            end
        endcase

        // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
        if (cfg_we)
        begin
            case (cfg_index)
                rkc_pkg::CFG_PRIME_P:
                begin
                    p_next     = cfg_data[PW-1:0];
                    fresh_next = 1'b0;
                end
                rkc_pkg::CFG_PRIME_Q:
                begin
                    q_next     = cfg_data[PW-1:0];
                    fresh_next = 1'b0;
                end
                rkc_pkg::CFG_PUB_EXP:
                begin
                    e_next     = cfg_data;
                    fresh_next = 1'b0;
                end
                default:
                begin
                    fresh_next = fresh_next;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            run_reg   <= 1'b0;
            fresh_reg <= 1'b0;
            p_reg     <= '0;
            q_reg     <= '0;
            e_reg     <= '0;
            dk_reg    <= '0;
            m_reg     <= '0;
            st_reg    <= rkc_pkg::ST_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            fresh_reg <= fresh_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            e_reg     <= e_next;
            dk_reg    <= dk_next;
            m_reg     <= m_next;
            st_reg    <= st_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg   <= phi_next;
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        which_reg <= which_next;
        dv_reg    <= dv_next;
        sq_reg    <= sq_next;
        oldr_reg  <= oldr_next;
        curr_reg  <= curr_next;
        olds_reg  <= olds_next;
        curs_reg  <= curs_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        ex_reg    <= ex_next;
        ph_reg    <= ph_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    rkc_mulmod u_mulmod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .x     (mm_x),
        .y     (mm_y),
        .m     (m_reg),
        .done  (mm_done),
        .z     (mm_z)
    );

    rkc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dv_req),
        .n     (dv_n),
        .d     (dv_d),
        .s     (dv_s),
        .done  (dv_done),
        .rem   (dv_rem),
        .prod  (dv_prod)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp_data  = out_reg;

    // A failed key check always answers zero.
    `RKC_ASSERT_SAME(a_err_zero, ov_reg && out_reg.status != rkc_pkg::ST_OK, out_reg.result == '0)
    // After a command transfer the input is closed (cmd_stall high).
    `RKC_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall)
    // The two serial units are never started in the same cycle.
    `RKC_ASSERT_NEVER(a_one_unit, mm_req.start && dv_req.start)

endmodule
